@@ rtl/fbrd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbrd_pkg
// Shared types and constants for the fixed-block record deframer.
// ----------------------------------------------------------------------------
package fbrd_pkg;

    localparam int WORD_W = 64;
    localparam int KEY_W  = 16;
    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;
    localparam int KIND_W = 2;

    localparam int BLOCK_WORDS_DEF      = 512;
    localparam int MAX_RECORD_WORDS_DEF = 1024;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_KEY    = 2'd1,
        PH_DATA   = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEY  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [LEN_W-1:0]   length;
        logic [IDX_W-1:0]   index;
        logic [WORD_W-1:0]  value;
        logic               last;
    } res_t;

endpackage
`default_nettype wire

@@ rtl/fbrd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbrd_in_if / fbrd_out_if
// Valid/ready channels for payload words in and record words out.
// ----------------------------------------------------------------------------
interface fbrd_in_if;
    logic                        valid;
    logic                        ready;
    logic [fbrd_pkg::WORD_W-1:0] payload_word;
    logic                        new_file;

    modport source (output valid, output payload_word, output new_file, input ready);
    modport sink   (input valid, input payload_word, input new_file, output ready);
endinterface

interface fbrd_out_if;
    logic                        valid;
    logic                        ready;
    logic [fbrd_pkg::KIND_W-1:0] word_kind;
    logic [fbrd_pkg::KEY_W-1:0]  record_key;
    logic [fbrd_pkg::LEN_W-1:0]  record_length;
    logic [fbrd_pkg::IDX_W-1:0]  data_index;
    logic [fbrd_pkg::WORD_W-1:0] data_value;
    logic                        last_of_record;

    modport source (output valid, output word_kind, output record_key, output record_length,
                    output data_index, output data_value, output last_of_record,
                    input ready);
    modport sink   (input valid, input word_kind, input record_key, input record_length,
                    input data_index, input data_value, input last_of_record,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/fixed_block_record_deframer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_record_deframer
// Splits a stream of fixed-block payload words into keyed record words.
// ----------------------------------------------------------------------------
// Takes one payload word per cycle while the sink keeps taking results, and
// gives at most one result per word: the word is captured in an input
// register, decoded against the parser state, and the result lands in an
// output register backed by a one-entry skid register. in_ch.ready depends
// only on registered state, so a new request is taken every cycle while the
// sink keeps taking results. Padding and skipped words give no result.
module fixed_block_record_deframer #(
    parameter int BLOCK_WORDS      = fbrd_pkg::BLOCK_WORDS_DEF,
    parameter int MAX_RECORD_WORDS = fbrd_pkg::MAX_RECORD_WORDS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    fbrd_in_if.sink     in_ch,
    fbrd_out_if.source  out_ch
);

    logic                        in_valid_reg;
    logic [fbrd_pkg::WORD_W-1:0] in_word_reg;
    logic                        in_nf_reg;
    logic                        step;
    logic                        emit;
    logic                        push;
    logic                        pop;
    fbrd_pkg::res_t              res;
    fbrd_pkg::res_t              main_reg;
    fbrd_pkg::res_t              skid_reg;
    logic                        main_valid_reg;
    logic                        skid_valid_reg;

    assign step        = in_valid_reg && !skid_valid_reg;
    assign in_ch.ready = !in_valid_reg || !skid_valid_reg;
    assign push        = step && emit;
    assign pop         = main_valid_reg && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_word_reg <= in_ch.payload_word;
            in_nf_reg   <= in_ch.new_file;
        end
    end

    fbrd_core #(
        .BLOCK_WORDS      (BLOCK_WORDS),
        .MAX_RECORD_WORDS (MAX_RECORD_WORDS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .word     (in_word_reg),
        .new_file (in_nf_reg),
        .res      (res),
        .emit     (emit)
    );

    // result register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= res;
            end
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign out_ch.valid          = main_valid_reg;
    assign out_ch.word_kind      = main_reg.kind;
    assign out_ch.record_key     = main_reg.key;
    assign out_ch.record_length  = main_reg.length;
    assign out_ch.data_index     = main_reg.index;
    assign out_ch.data_value     = main_reg.value;
    assign out_ch.last_of_record = main_reg.last;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without an output entry");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !out_ch.ready))
        else $error("skid filled while output was free");

    a_key_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.word_kind == fbrd_pkg::KIND_KEY) |-> out_ch.data_index == '0)
        else $error("key word with nonzero data index");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && skid_valid_reg) |=> in_valid_reg && $stable(in_word_reg))
        else $error("input word lost during stall");

endmodule
`default_nettype wire

@@ rtl/fbrd_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbrd_core
// Record parser state and per-word decode; one word per step.
// ----------------------------------------------------------------------------
module fbrd_core #(
    parameter int BLOCK_WORDS      = fbrd_pkg::BLOCK_WORDS_DEF,
    parameter int MAX_RECORD_WORDS = fbrd_pkg::MAX_RECORD_WORDS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [fbrd_pkg::WORD_W-1:0] word,
    input  wire logic                        new_file,
    output fbrd_pkg::res_t                   res,
    output logic                             emit
);

    localparam int WW    = fbrd_pkg::WORD_W;
    localparam int LW    = fbrd_pkg::LEN_W;
    localparam int KW    = fbrd_pkg::KEY_W;
    localparam int IW    = fbrd_pkg::IDX_W;
    localparam int POS_W = $clog2(BLOCK_WORDS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_WORDS - 1);
    localparam logic [WW-1:0]    MAX_LEN  = WW'(MAX_RECORD_WORDS);

    logic [POS_W-1:0]  pos_reg, pos_next, pos_cur;
    fbrd_pkg::phase_t  phase_reg, phase_next, phase_cur, phase_upd;
    logic [LW-1:0]     rem_reg, rem_next, rem_cur, rem_dec;
    logic [LW-1:0]     len_reg, len_next, len_cur;
    logic [KW-1:0]     key_reg, key_next, key_cur;
    logic [IW-1:0]     cnt_reg, cnt_next, cnt_cur;
    logic              pad_word;
    logic              bad_long;

    // new file restarts the parse before this word is handled
    always_comb
    begin
        if (new_file)
        begin
            pos_cur   = '0;
            phase_cur = fbrd_pkg::PH_LENGTH;
            rem_cur   = '0;
            len_cur   = '0;
            key_cur   = '0;
            cnt_cur   = '0;
        end
        else
        begin
            pos_cur   = pos_reg;
            phase_cur = phase_reg;
            rem_cur   = rem_reg;
            len_cur   = len_reg;
            key_cur   = key_reg;
            cnt_cur   = cnt_reg;
        end
    end

    assign rem_dec  = (rem_cur != '0) ? rem_cur - LW'(1) : '0;
    assign pad_word = (word == '0) || word[WW-1];
    assign bad_long = (word > MAX_LEN);

    // next state
    always_comb
    begin
        phase_upd = phase_cur;
        rem_next  = rem_cur;
        len_next  = len_cur;
        key_next  = key_cur;
        cnt_next  = cnt_cur;
        case (phase_cur)
            fbrd_pkg::PH_LENGTH:
            begin
                if (pad_word)
                begin
                    phase_upd = fbrd_pkg::PH_SKIP;
                end
                else if (word == WW'(1))
                begin
                    phase_upd = fbrd_pkg::PH_LENGTH;
                end
                else if (bad_long)
                begin
                    phase_upd = fbrd_pkg::PH_SKIP;
                end
                else
                begin
                    len_next  = word[LW-1:0];
                    rem_next  = word[LW-1:0] - LW'(1);
                    phase_upd = fbrd_pkg::PH_KEY;
                end
            end
            fbrd_pkg::PH_KEY:
            begin
                key_next  = word[KW-1:0];
                cnt_next  = '0;
                rem_next  = rem_dec;
                phase_upd = (rem_dec == '0) ? fbrd_pkg::PH_LENGTH : fbrd_pkg::PH_DATA;
            end
            fbrd_pkg::PH_DATA:
            begin
                rem_next = rem_dec;
                cnt_next = cnt_cur + IW'(1);
                if (rem_dec == '0)
                begin
                    phase_upd = fbrd_pkg::PH_LENGTH;
                end
            end
            default:
            begin
                phase_upd = phase_cur;
            end
        endcase

        phase_next = phase_upd;
        if (pos_cur == LAST_POS)
        begin
            pos_next = '0;
            if (phase_upd == fbrd_pkg::PH_SKIP)
            begin
                phase_next = fbrd_pkg::PH_LENGTH;
            end
        end
        else
        begin
            pos_next = pos_cur + POS_W'(1);
        end
    end

    // result
    always_comb
    begin
        emit       = 1'b0;
        res.kind   = fbrd_pkg::KIND_DATA;
        res.key    = key_cur;
        res.length = len_cur;
        res.index  = cnt_cur;
        res.value  = word;
        res.last   = (rem_dec == '0);
        case (phase_cur)
            fbrd_pkg::PH_LENGTH:
            begin
                res.kind  = fbrd_pkg::KIND_BAD;
                res.key   = '0;
                res.index = '0;
                res.last  = 1'b1;
                if (!pad_word && word == WW'(1))
                begin
                    emit       = 1'b1;
                    res.length = LW'(1);
                end
                else
                begin
                    emit       = !pad_word && bad_long;
                    res.length = '0;
                end
            end
            fbrd_pkg::PH_KEY:
            begin
                emit      = 1'b1;
                res.kind  = fbrd_pkg::KIND_KEY;
                res.key   = word[KW-1:0];
                res.index = '0;
            end
            fbrd_pkg::PH_DATA:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= fbrd_pkg::PH_LENGTH;
            rem_reg   <= '0;
            len_reg   <= '0;
            key_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-block record deframer. A scoreboard class
// predicts the expected record words from every accepted payload word and
// checks each result, in order, field by field. One file runs to the end of
// its first block under four sender and receiver idle settings, with random
// records and bad lengths, and ends the block with a skip on its last word.
// Directed words then cover padding, bad lengths and new files inside a record.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WORD_W      = fbrd_pkg::WORD_W;
    localparam int KEY_W       = fbrd_pkg::KEY_W;
    localparam int LEN_W       = fbrd_pkg::LEN_W;
    localparam int IDX_W       = fbrd_pkg::IDX_W;
    localparam int KIND_W      = fbrd_pkg::KIND_W;
    localparam int BLOCK_WORDS = fbrd_pkg::BLOCK_WORDS_DEF;
    localparam int MAX_WORDS   = fbrd_pkg::MAX_RECORD_WORDS_DEF;
    localparam logic [WORD_W-1:0] OVER_LEN = WORD_W'(MAX_WORDS + 1);

    class record_scoreboard;
        fbrd_pkg::phase_t phase;
        int               blk_pos;
        logic [LEN_W-1:0] remaining;
        logic [LEN_W-1:0] cur_len;
        logic [KEY_W-1:0] cur_key;
        logic [IDX_W-1:0] data_cnt;
        fbrd_pkg::res_t   expected_q[$];
        int               errors;
        int               checked;
        int               results_noted;
        int               words_noted;
        int               files_noted;

        function new();
            clear_state();
            errors        = 0;
            checked       = 0;
            results_noted = 0;
            words_noted   = 0;
            files_noted   = 0;
        endfunction

        function void clear_state();
            phase     = fbrd_pkg::PH_LENGTH;
            blk_pos   = 0;
            remaining = '0;
            cur_len   = '0;
            cur_key   = '0;
            data_cnt  = '0;
        endfunction

        function void push_result(fbrd_pkg::kind_t k, logic [KEY_W-1:0] key,
                                  logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                                  logic [WORD_W-1:0] value, logic last);
            fbrd_pkg::res_t r;
            r.kind   = k;
            r.key    = key;
            r.length = len;
            r.index  = idx;
            r.value  = value;
            r.last   = last;
            expected_q.push_back(r);
            results_noted++;
        endfunction

        function void note_word(logic [WORD_W-1:0] w, logic nf);
            words_noted++;
            if (nf)
            begin
                files_noted++;
                clear_state();
            end
            case (phase)
                fbrd_pkg::PH_LENGTH:
                begin
                    if (w == '0 || w[WORD_W-1])
                    begin
                        phase = fbrd_pkg::PH_SKIP;
                    end
                    else if (w == WORD_W'(1))
                    begin
                        push_result(fbrd_pkg::KIND_BAD, '0, LEN_W'(1), '0, w, 1'b1);
                    end
                    else if (w > WORD_W'(MAX_WORDS))
                    begin
                        push_result(fbrd_pkg::KIND_BAD, '0, '0, '0, w, 1'b1);
                        phase = fbrd_pkg::PH_SKIP;
                    end
                    else
                    begin
                        cur_len   = w[LEN_W-1:0];
                        remaining = cur_len - LEN_W'(1);
                        phase     = fbrd_pkg::PH_KEY;
                    end
                end
                fbrd_pkg::PH_KEY:
                begin
                    cur_key  = w[KEY_W-1:0];
                    data_cnt = '0;
                    if (remaining != '0)
                        remaining = remaining - LEN_W'(1);
                    push_result(fbrd_pkg::KIND_KEY, cur_key, cur_len, '0, w, remaining == '0);
                    phase = (remaining == '0) ? fbrd_pkg::PH_LENGTH : fbrd_pkg::PH_DATA;
                end
                fbrd_pkg::PH_DATA:
                begin
                    if (remaining != '0)
                        remaining = remaining - LEN_W'(1);
                    push_result(fbrd_pkg::KIND_DATA, cur_key, cur_len, data_cnt, w,
                                remaining == '0);
                    data_cnt = data_cnt + IDX_W'(1);
                    if (remaining == '0)
                        phase = fbrd_pkg::PH_LENGTH;
                end
                default:
                begin
                end
            endcase
            blk_pos++;
            if (blk_pos >= BLOCK_WORDS)
            begin
                blk_pos = 0;
                if (phase == fbrd_pkg::PH_SKIP)
                    phase = fbrd_pkg::PH_LENGTH;
            end
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] exp_v,
                                    logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                                   logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                                   logic [WORD_W-1:0] value, logic last);
            fbrd_pkg::res_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: kind %0d value 0x%0h", k, value);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare_field("word_kind", WORD_W'(e.kind), WORD_W'(k));
            compare_field("record_key", WORD_W'(e.key), WORD_W'(key));
            compare_field("record_length", WORD_W'(e.length), WORD_W'(len));
            compare_field("data_index", WORD_W'(e.index), WORD_W'(idx));
            compare_field("data_value", e.value, value);
            compare_field("last_of_record", WORD_W'(e.last), WORD_W'(last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    record_scoreboard sb = new();

    fbrd_in_if  in_ch();
    fbrd_out_if out_ch();

    fixed_block_record_deframer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.word_kind, out_ch.record_key, out_ch.record_length,
                            out_ch.data_index, out_ch.data_value, out_ch.last_of_record);
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [WORD_W-1:0] w, input logic nf);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.payload_word = w;
        in_ch.new_file     = nf;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_word(w, nf);
        @(negedge clk);
    endtask

    // length word, key word and data words
    task automatic send_record(input int len, input logic nf);
        int i;
        send_word(WORD_W'(len), nf);
        for (i = 1; i < len; i++)
            send_word(rand64(), 1'b0);
    endtask

    // random records and length-one words, kept inside the current block
    task automatic run_random(input int n_words);
        int start;
        int r;
        int len;
        start = sb.words_noted;
        while (sb.words_noted - start < n_words)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_word(WORD_W'(1), 1'b0);
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 70)
                    len = $urandom_range(4, 2);
                else if (r < 95)
                    len = $urandom_range(16, 5);
                else
                    len = $urandom_range(39, 17);
                send_record(len, 1'b0);
            end
        end
    endtask

    // fill up to the last word of the block, then start a skip on it
    task automatic run_to_block_end();
        int space;
        int len;
        space = BLOCK_WORDS - 1 - sb.blk_pos;
        while (space > 0)
        begin
            if (space < 4 || $urandom_range(99) < 8)
            begin
                send_word(WORD_W'(1), 1'b0);
            end
            else
            begin
                len = $urandom_range(16, 2);
                if (len > space)
                    len = space;
                send_record(len, 1'b0);
            end
            space = BLOCK_WORDS - 1 - sb.blk_pos;
        end
        send_word(($urandom_range(1) == 0) ? OVER_LEN : 64'h8000_0000_0000_0000, 1'b0);
    endtask

    task automatic run_file_start();
        send_word(64'd2, 1'b1);
        send_word('1, 1'b0);
        send_word(64'd4, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_0000, 1'b0);
        send_word(64'd0, 1'b0);
        send_word('1, 1'b0);
        send_word(64'd1, 1'b0);
    endtask

    task automatic run_tail();
        send_record(3, 1'b0);
        // longest length, cut short by a new file
        send_word(WORD_W'(MAX_WORDS), 1'b0);
        send_word('1, 1'b0);
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);
        send_word(64'd5, 1'b1);
        send_word(rand64(), 1'b0);
        send_word(rand64(), 1'b0);
        // padding and bad lengths, each ended by a new file
        send_word(64'd0, 1'b1);
        send_word(rand64(), 1'b0);
        send_word(64'h8000_0000_0000_0001, 1'b1);
        send_word(rand64(), 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(rand64(), 1'b0);
        send_word(OVER_LEN, 1'b1);
        send_word(64'd1, 1'b0);
        send_record(2, 1'b1);
    endtask

    initial
    begin
        in_ch.valid        = 1'b0;
        in_ch.payload_word = '0;
        in_ch.new_file     = 1'b0;
        out_ch.ready       = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rst_n              = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_file_start();
        run_random(120);
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        run_random(120);
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        run_random(120);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        run_to_block_end();
        run_tail();

        in_ch.valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d payload words over %0d files; %0d record words checked.",
                 sb.words_noted, sb.files_noted, sb.checked);
        $display("Covered records, bad lengths, padding, a skip on a block's last word,");
        $display("new files inside records and four idle mixes.");
        if (sb.errors == 0)
            $display("fixed_block_record_deframer verification clean");
        else
            $display("fixed_block_record_deframer verification failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("fixed_block_record_deframer verification failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/fbrd_pkg.sv
rtl/fbrd_if.sv
rtl/fbrd_core.sv
rtl/fixed_block_record_deframer.sv
tb/testbench.sv
